FILE: sv/vdr_pkg.sv
package vdr_pkg;

  // Sizes
  localparam int unsigned MaxPointsDef = 256;
  localparam int unsigned CoordW       = 32;
  localparam int unsigned OpW          = 2;
  localparam int unsigned OrigW        = 8;
  localparam int unsigned IdxOutW      = 8;
  localparam int unsigned TotalW       = 9;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned InDataW      = 104;
  localparam int unsigned OutDataW     = 24;

  // Operation codes
  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_REMAP  = 2'd1;
  localparam logic [OpW-1:0] OP_CLEAR  = 2'd2;

  // Status codes
  localparam logic [StatusW-1:0] STAT_OK       = 2'd0;
  localparam logic [StatusW-1:0] STAT_FULL     = 2'd1;
  localparam logic [StatusW-1:0] STAT_NO_ENTRY = 2'd2;

  // One point, x in the low bits
  typedef struct packed {
    logic [CoordW-1:0] z;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } point_t;

  // One result item, compact index in the low bits
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [TotalW-1:0]  total;
    logic               dup;
    logic [IdxOutW-1:0] idx;
  } result_t;

endpackage

FILE: sv/vertex_dedup_reindex_core.sv
// Channel  Dir  Fields (lowest bit first)
// s_axis   in   tuser: op[1:0]; tdata: coord_x, coord_y, coord_z, original_index
// m_axis   out  tdata: compact_index, is_duplicate, unique_total, status, zero pad
//
// Insert: the point walks the row of MaxPoints compare cells, one cell a cycle,
// and its result is built when it leaves the last cell. Remap: registered read
// of the remap memory. Clear, full insert, unused op: result is set on accept.
// One item is in work at a time; the next is taken once its result has moved
// to the output register, which may still wait on m_axis_tready.
// Reset empties the level (counts zero); no clearing pass is needed.
module vertex_dedup_reindex_core
  import vdr_pkg::*;
#(
  parameter int unsigned MaxPoints = MaxPointsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // coord_x, coord_y, coord_z, original_index
  input  logic [OpW-1:0]      s_axis_tuser,  // op
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // compact_index, is_duplicate, unique_total,
                                             // status, pad
);

  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);

  logic                busy_q, busy_d;
  logic [CntW-1:0]     ps_q, ps_d;
  logic [CntW-1:0]     uc_q, uc_d;
  logic                rmp_q, rmp_d;
  logic                rmp_ok_q, rmp_ok_d;
  logic                pend_vld_q, pend_vld_d;
  result_t             pend_q, pend_d;
  logic                out_vld_q;
  result_t             out_q;
  logic [IdxW-1:0]     rd_q;
  logic [IdxW-1:0]     remap_mem [MaxPoints];

  logic                accept;
  logic                out_free;
  logic                full;
  logic                launch;
  point_t              in_pt;
  logic [OrigW-1:0]    orig;
  logic                orig_ok;
  logic [IdxW-1:0]     rd_addr;
  logic [IdxW+OrigW-1:0] orig_wide;
  logic                end_vld;
  logic                end_hit;
  logic [IdxW-1:0]     end_idx;
  logic [IdxW-1:0]     end_slot;
  logic [CntW-1:0]     uc_inc;
  logic [CntW-1:0]     uc_new;
  logic [IdxW+IdxOutW-1:0]  slot_ext;
  logic [IdxW+IdxOutW-1:0]  rd_ext;
  logic [CntW+TotalW-1:0]   uc_ext;
  logic [CntW+TotalW-1:0]   uc_new_ext;

  // Unpack the input item
  assign in_pt.x = s_axis_tdata[31:0];
  assign in_pt.y = s_axis_tdata[63:32];
  assign in_pt.z = s_axis_tdata[95:64];
  assign orig    = s_axis_tdata[103:96];

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  assign full    = ps_q >= CntW'(MaxPoints);
  assign launch  = accept && (s_axis_tuser == OP_INSERT) && !full;

  // Remap range check and memory address
  assign orig_wide = {{IdxW{1'b0}}, orig};
  assign rd_addr   = orig_wide[IdxW-1:0];
  assign orig_ok   = {{CntW{1'b0}}, orig} < {{OrigW{1'b0}}, ps_q};

  vdr_chain #(
    .MaxPoints (MaxPoints),
    .IdxW      (IdxW),
    .CntW      (CntW)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .launch_i (launch),
    .pt_i     (in_pt),
    .count_i  (uc_q),
    .done_o   (end_vld),
    .hit_o    (end_hit),
    .idx_o    (end_idx)
  );

  // Outcome of a finished insert
  assign uc_inc     = uc_q + 1'b1;
  assign uc_new     = end_hit ? uc_q : uc_inc;
  assign end_slot   = end_hit ? end_idx : uc_q[IdxW-1:0];
  assign slot_ext   = {{IdxOutW{1'b0}}, end_slot};
  assign rd_ext     = {{IdxOutW{1'b0}}, rd_q};
  assign uc_ext     = {{TotalW{1'b0}}, uc_q};
  assign uc_new_ext = {{TotalW{1'b0}}, uc_new};

  // Remap memory: write on insert completion, registered read on remap
  always_ff @(posedge clk_i) begin
    if (end_vld) begin
      remap_mem[ps_q[IdxW-1:0]] <= end_slot;
    end
    if (accept && (s_axis_tuser == OP_REMAP)) begin
      rd_q <= remap_mem[rd_addr];
    end
  end

  // Sequence one item and build its result
  always_comb begin
    busy_d     = busy_q;
    ps_d       = ps_q;
    uc_d       = uc_q;
    rmp_d      = 1'b0;
    rmp_ok_d   = rmp_ok_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;

    if (pend_vld_q && out_free) begin
      pend_vld_d = 1'b0;
      busy_d     = 1'b0;
    end

    if (accept) begin
      busy_d = 1'b1;
      case (s_axis_tuser)
        OP_INSERT: begin
          if (full) begin
            pend_vld_d    = 1'b1;
            pend_d.idx    = '0;
            pend_d.dup    = 1'b0;
            pend_d.total  = uc_ext[TotalW-1:0];
            pend_d.status = STAT_FULL;
          end
        end
        OP_REMAP: begin
          rmp_d    = 1'b1;
          rmp_ok_d = orig_ok;
        end
        OP_CLEAR: begin
          ps_d          = '0;
          uc_d          = '0;
          pend_vld_d    = 1'b1;
          pend_d.idx    = '0;
          pend_d.dup    = 1'b0;
          pend_d.total  = '0;
          pend_d.status = STAT_OK;
        end
        default: begin
          pend_vld_d    = 1'b1;
          pend_d.idx    = '0;
          pend_d.dup    = 1'b0;
          pend_d.total  = uc_ext[TotalW-1:0];
          pend_d.status = STAT_OK;
        end
      endcase
    end

    if (rmp_q) begin
      pend_vld_d    = 1'b1;
      pend_d.idx    = rmp_ok_q ? rd_ext[IdxOutW-1:0] : '0;
      pend_d.dup    = 1'b0;
      pend_d.total  = uc_ext[TotalW-1:0];
      pend_d.status = rmp_ok_q ? STAT_OK : STAT_NO_ENTRY;
    end

    if (end_vld) begin
      ps_d          = ps_q + 1'b1;
      uc_d          = uc_new;
      pend_vld_d    = 1'b1;
      pend_d.idx    = slot_ext[IdxOutW-1:0];
      pend_d.dup    = end_hit;
      pend_d.total  = uc_new_ext[TotalW-1:0];
      pend_d.status = STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      ps_q       <= '0;
      uc_q       <= '0;
      rmp_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      ps_q       <= ps_d;
      uc_q       <= uc_d;
      rmp_q      <= rmp_d;
      pend_vld_q <= pend_vld_d;
      if (out_free) begin
        out_vld_q <= pend_vld_q;
      end
    end
  end

  // Hold payloads; move the pending result into the output register
  always_ff @(posedge clk_i) begin
    rmp_ok_q <= rmp_ok_d;
    pend_q   <= pend_d;
    if (pend_vld_q && out_free) begin
      out_q <= pend_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_q};

endmodule

FILE: sv/vdr_cell.sv
module vdr_cell
  import vdr_pkg::*;
#(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned IdxW    = 8,
  parameter int unsigned CntW    = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  point_t          pt_i,
  input  logic            hit_i,
  input  logic [IdxW-1:0] idx_i,
  input  logic [CntW-1:0] count_i,
  output logic            vld_o,
  output point_t          pt_o,
  output logic            hit_o,
  output logic [IdxW-1:0] idx_o
);

  localparam logic [CntW-1:0] Slot    = CntW'(CellIdx);
  localparam logic [IdxW-1:0] SlotIdx = IdxW'(CellIdx);

  point_t          ent_q;
  logic            vld_q;
  point_t          pt_q;
  logic            hit_q;
  logic [IdxW-1:0] idx_q;
  logic            live;
  logic            take;
  logic            fill;

  // Compare only against a stored unique point of this level
  assign live = Slot < count_i;
  assign take = vld_i && !hit_i && live && (ent_q == pt_i);
  // First free slot keeps a point that matched nothing upstream
  assign fill = vld_i && !hit_i && (Slot == count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // Advance the query, mark the first match
  always_ff @(posedge clk_i) begin
    pt_q  <= pt_i;
    hit_q <= hit_i || take;
    idx_q <= take ? SlotIdx : idx_i;
    if (fill) begin
      ent_q <= pt_i;
    end
  end

  assign vld_o = vld_q;
  assign pt_o  = pt_q;
  assign hit_o = hit_q;
  assign idx_o = idx_q;

endmodule

FILE: sv/vdr_chain.sv
module vdr_chain
  import vdr_pkg::*;
#(
  parameter int unsigned MaxPoints = MaxPointsDef,
  parameter int unsigned IdxW      = 8,
  parameter int unsigned CntW      = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            launch_i,
  input  point_t          pt_i,
  input  logic [CntW-1:0] count_i,
  output logic            done_o,
  output logic            hit_o,
  output logic [IdxW-1:0] idx_o
);

  logic            vld [MaxPoints+1];
  point_t          pt  [MaxPoints+1];
  logic            hit [MaxPoints+1];
  logic [IdxW-1:0] idx [MaxPoints+1];

  // Query enters cell zero with no match yet
  assign vld[0] = launch_i;
  assign pt[0]  = pt_i;
  assign hit[0] = 1'b0;
  assign idx[0] = '0;

  for (genvar k = 0; k < MaxPoints; k++) begin : g_cell
    vdr_cell #(
      .CellIdx (k),
      .IdxW    (IdxW),
      .CntW    (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .vld_i   (vld[k]),
      .pt_i    (pt[k]),
      .hit_i   (hit[k]),
      .idx_i   (idx[k]),
      .count_i (count_i),
      .vld_o   (vld[k+1]),
      .pt_o    (pt[k+1]),
      .hit_o   (hit[k+1]),
      .idx_o   (idx[k+1])
    );
  end

  assign done_o = vld[MaxPoints];
  assign hit_o  = hit[MaxPoints];
  assign idx_o  = idx[MaxPoints];

endmodule
